// ===== rtl/core/tthd_pkg.sv =====
// Shared types and constants for the touch tap and hold detector.
`default_nettype none

package tthd_pkg;

	// Field widths.
	localparam int unsigned SampleW = 10;
	localparam int unsigned IntegW  = 4;
	localparam int unsigned DurW    = 8;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 10;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_LEVEL_THRESHOLD = 3'd0,
		REG_DIFF_THRESHOLD  = 3'd1,
		REG_INTEGRATOR_MAX  = 3'd2,
		REG_ON_LEVEL        = 3'd3,
		REG_HOLD_COUNT      = 3'd4
	} cfg_reg_t;

	// Item kinds carried in the input tuser bit.
	localparam logic FUNC_SAMPLE   = 1'b0;
	localparam logic FUNC_READ_TAP = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [SampleW-1:0] LEVEL_THRESHOLD_RST = 10'd512;
	localparam logic [SampleW-1:0] DIFF_THRESHOLD_RST  = 10'd20;
	localparam logic [IntegW-1:0]  INTEGRATOR_MAX_RST  = 4'd10;
	localparam logic [IntegW-1:0]  ON_LEVEL_RST        = 4'd5;
	localparam logic [DurW-1:0]    HOLD_COUNT_RST      = 8'd100;

	// Current configuration as seen by the update logic.
	typedef struct packed {
		logic [SampleW-1:0] level_threshold;
		logic [SampleW-1:0] diff_threshold;
		logic [IntegW-1:0]  integrator_max;
		logic [IntegW-1:0]  on_level;
		logic [DurW-1:0]    hold_count;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic tapped;
		logic holding;
		logic touching;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/tthd_cfg.sv =====
// Configuration register file of the touch tap and hold detector.
`default_nettype none

module tthd_cfg
	import tthd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	// Write the addressed register; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_threshold <= LEVEL_THRESHOLD_RST;
			cfg_q.diff_threshold  <= DIFF_THRESHOLD_RST;
			cfg_q.integrator_max  <= INTEGRATOR_MAX_RST;
			cfg_q.on_level        <= ON_LEVEL_RST;
			cfg_q.hold_count      <= HOLD_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEVEL_THRESHOLD: cfg_q.level_threshold <= cfg_data[SampleW-1:0];
				REG_DIFF_THRESHOLD:  cfg_q.diff_threshold  <= cfg_data[SampleW-1:0];
				REG_INTEGRATOR_MAX:  cfg_q.integrator_max  <= cfg_data[IntegW-1:0];
				REG_ON_LEVEL:        cfg_q.on_level        <= cfg_data[IntegW-1:0];
				REG_HOLD_COUNT:      cfg_q.hold_count      <= cfg_data[DurW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/tthd_update.sv =====
// Touch state registers and the single-pass update for one item.
`default_nettype none

module tthd_update
	import tthd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               func,
	input  wire logic [SampleW-1:0] sample,
	input  wire cfg_t               cfg,
	output result_t                 result
);

	logic [SampleW-1:0] prev_q;
	logic [IntegW-1:0]  integ_q;
	logic [DurW-1:0]    dur_q;
	logic               touching_q;
	logic               holding_q;
	logic               tap_q;

	logic [SampleW-1:0] diff;
	logic               hit;
	logic [IntegW-1:0]  integ_d;
	logic [DurW-1:0]    dur_inc;
	logic [DurW-1:0]    dur_d;
	logic               touching_d;
	logic               holding_d;
	logic               tap_d;
	logic [SampleW-1:0] prev_d;

	// Hit detection: absolute level or sample-to-sample change.
	always_comb begin
		diff = (prev_q > sample) ? (prev_q - sample) : (sample - prev_q);
		hit  = (sample > cfg.level_threshold) || (diff > cfg.diff_threshold);
	end

	// Next state for this item.
	always_comb begin
		prev_d     = prev_q;
		integ_d    = integ_q;
		dur_d      = dur_q;
		touching_d = touching_q;
		holding_d  = holding_q;
		tap_d      = tap_q;
		dur_inc    = (dur_q != {DurW{1'b1}}) ? (dur_q + DurW'(1)) : dur_q;
		if (func == FUNC_READ_TAP) begin
			tap_d = 1'b0;
		end else begin
			prev_d = sample;
			// Saturating integrator: up on a hit, down on a miss.
			if (hit) begin
				if (integ_q < cfg.integrator_max) integ_d = integ_q + IntegW'(1);
			end else if (integ_q != '0) begin
				integ_d = integ_q - IntegW'(1);
			end
			// Touch qualification, duration count and release handling.
			if (integ_d >= cfg.on_level) begin
				touching_d = 1'b1;
				if (dur_inc >= cfg.hold_count) begin
					holding_d = 1'b1;
					dur_d     = cfg.hold_count;
				end else begin
					dur_d = dur_inc;
				end
			end else if (touching_q) begin
				touching_d = 1'b0;
				holding_d  = 1'b0;
				if (dur_q < cfg.hold_count) tap_d = 1'b1;
				dur_d = '0;
			end
		end
	end

	// The result reports flags after the item; a read reports the tap flag before clearing.
	always_comb begin
		result.touching = touching_d;
		result.holding  = holding_d;
		result.tapped   = (func == FUNC_READ_TAP) ? tap_q : tap_d;
	end

	// State registers advance once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			integ_q    <= '0;
			dur_q      <= '0;
			touching_q <= 1'b0;
			holding_q  <= 1'b0;
			tap_q      <= 1'b0;
		end else if (en) begin
			prev_q     <= prev_d;
			integ_q    <= integ_d;
			dur_q      <= dur_d;
			touching_q <= touching_d;
			holding_q  <= holding_d;
			tap_q      <= tap_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/touch_tap_hold_detector.sv =====
// Top level of the touch tap and hold detector: input and result registers.
//
//  Channel   Ports                        Beat contents (lowest bit first)
//  input     s_tvalid s_tready s_tdata    s_tdata: sample[9:0], zero pad to 16
//                     s_tuser             s_tuser: func (0 sample, 1 read tap)
//  result    m_tvalid m_tready m_tdata    m_tdata: touching, holding, tapped, pad to 8
//  config    cfg_we cfg_index cfg_data    index 0..4 per register list
//
// One beat per cycle is accepted while no stalled result blocks the input register; a
// beat fills the input register when accepted, and the update writes its result into the
// result register when that register is free or drains. The state update is one pass
// of compares and 4/8-bit counter steps. A stalled result holds in the result register
// while the input register still fills, so one more beat is taken.
// Reset clears all touch state and restores the register defaults.
`default_nettype none

module touch_tap_hold_detector
	import tthd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [15:0]         s_tdata,   // [9:0] sample, [15:10] zero
	input  wire logic                s_tuser,   // [0] func
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [7:0]               m_tdata,   // [0] touching, [1] holding, [2] tapped
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	cfg_t               cfg;
	result_t            result;
	logic               valid_s1;
	logic               func_s1;
	logic [SampleW-1:0] sample_s1;
	logic               valid_s2;
	result_t            result_s2;
	logic               advance;

	tthd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1 moves into the result register when that register is free or drains.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	tthd_update u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.func   (func_s1),
		.sample (sample_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (!valid_s2 || m_tready) valid_s2 <= valid_s1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1   <= s_tuser;
			sample_s1 <= s_tdata[SampleW-1:0];
		end
		if (advance) result_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, result_s2.tapped, result_s2.holding, result_s2.touching};

endmodule

`default_nettype wire
